/* sv/serial_frame_proxy_rewriter_macros.svh */
// Assertion macros shared by the serial frame proxy rewriter RTL.
`ifndef SERIAL_FRAME_PROXY_REWRITER_MACROS_SVH
`define SERIAL_FRAME_PROXY_REWRITER_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is ignored while reset is asserted.
`define SFPR_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfpr assertion failed");

// Clocked check that also holds during reset.
`define SFPR_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sfpr assertion failed");

`else

`define SFPR_ASSERT_RST(lbl, clk, rst_n, prop)
`define SFPR_ASSERT(lbl, clk, prop)

`endif

`endif

/* sv/sfpr_pkg.sv */
// Constants for the serial frame proxy rewriter.
package sfpr_pkg;

  // Frame sync byte and the pool frame type that carries the temperature.
  localparam logic [7:0] SYNC_BYTE = 8'hA5;
  localparam logic [7:0] TEMP_TYPE = 8'd6;

  // Remote frame types that are heater commands.
  localparam logic [7:0] CMD_TYPE_A = 8'd1;
  localparam logic [7:0] CMD_TYPE_B = 8'd2;

  // Source of an input byte.
  localparam logic SRC_POOL   = 1'b0;
  localparam logic SRC_REMOTE = 1'b1;

  // Frame positions after the sync byte: count values of the type, value and checksum bytes.
  localparam logic [1:0] POS_TYPE  = 2'd1;
  localparam logic [1:0] POS_VALUE = 2'd2;
  localparam logic [1:0] POS_CSUM  = 2'd3;

  // Number of results minus one for a one-result and a four-result burst.
  localparam logic [1:0] LEN_ONE  = 2'd0;
  localparam logic [1:0] LEN_FOUR = 2'd3;

endpackage

/* sv/serial_frame_proxy_rewriter.sv */
// Serial frame proxy rewriter: pool byte relay, temperature parse and remote frame rewrite.
//
// The block takes one byte per transfer, tagged with its side. A byte goes into an
// input register and is processed from there once its result, if any, can be
// loaded into a result burst register of up to four results; the burst drains
// one result per cycle on the output channel while out_stall is low. A pool byte
// or a bad remote frame gives a one-result burst, a good remote frame a
// four-result burst, and a remote byte that does not complete a frame gives none.
// A new byte is accepted every cycle while results are taken at once. A good
// remote frame holds the burst register until its four results have drained, so
// a byte right after its checksum that has a result of its own waits for them;
// since such a frame takes four input bytes, the sustained rate stays one byte
// per cycle, set by the single output port. The heater override is written
// through the configuration port, which is always ready.
`include "serial_frame_proxy_rewriter_macros.svh"

module serial_frame_proxy_rewriter (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_byte,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_to_pool,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic       out_frame_error,
  output logic       out_temp_update,
  output logic [7:0] out_temperature,
  // Configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_heater_override
);
  import sfpr_pkg::*;

  // Input register
  logic       in_valid_r;
  logic       in_action_r;
  logic [7:0] in_byte_r;

  // Configuration register
  logic       heater_override_r;

  // Pool frame assembler
  logic       pool_in_frame_r, pool_in_frame_nxt;
  logic [1:0] pool_count_r, pool_count_nxt;
  logic [7:0] pool_type_r, pool_type_nxt;
  logic [7:0] pool_value_r, pool_value_nxt;

  // Remote frame assembler
  logic       remote_in_frame_r, remote_in_frame_nxt;
  logic [1:0] remote_count_r, remote_count_nxt;
  logic [7:0] remote_type_r, remote_type_nxt;
  logic [7:0] remote_value_r, remote_value_nxt;

  // Temperature tracking
  logic [7:0] last_temperature_r, last_temperature_nxt;
  logic       temperature_known_r, temperature_known_nxt;

  // Result burst register
  logic       burst_valid_r;
  logic [7:0] burst_bytes_r [4];
  logic [7:0] burst_bytes_nxt [4];
  logic [1:0] burst_len_r, burst_len_nxt;
  logic [1:0] burst_idx_r;
  logic       burst_to_pool_r, burst_to_pool_nxt;
  logic       burst_byte_valid_r, burst_byte_valid_nxt;
  logic       burst_err_r, burst_err_nxt;
  logic       burst_tupd_r, burst_tupd_nxt;
  logic [7:0] burst_temp_r, burst_temp_nxt;
  logic       burst_load;

  // Handshake terms
  logic in_xfer;
  logic out_xfer;
  logic burst_done;
  logic burst_free;
  logic has_result;
  logic advance;

  // Processing terms
  logic       pool_complete;
  logic       remote_complete;
  logic [7:0] pool_sum;
  logic [7:0] remote_sum;
  logic [7:0] remote_value_fwd;
  logic [7:0] remote_sum_fwd;

  // Handshake control: the input register advances when it has no result or its result can be loaded.
  assign in_xfer    = in_valid && !in_stall;
  assign out_xfer   = out_valid && !out_stall;
  assign burst_done = out_xfer && (burst_idx_r == burst_len_r);
  assign burst_free = !burst_valid_r || burst_done;
  assign has_result = (in_action_r == SRC_POOL) || remote_complete;
  assign advance    = in_valid_r && (!has_result || burst_free);
  assign in_stall   = in_valid_r && !advance;
  assign cfg_ready  = 1'b1;

  // Frame completion and checksums seen from the input register.
  assign pool_complete   = pool_in_frame_r && (pool_count_r == POS_CSUM);
  assign remote_complete = remote_in_frame_r && (remote_count_r == POS_CSUM);
  assign pool_sum        = SYNC_BYTE + pool_type_r + pool_value_r;
  assign remote_sum      = SYNC_BYTE + remote_type_r + remote_value_r;

  // The override turns an off command of a heater type into an on command.
  always_comb begin
    remote_value_fwd = remote_value_r;
    if (heater_override_r && (remote_value_r == 8'd0) &&
        ((remote_type_r == CMD_TYPE_A) || (remote_type_r == CMD_TYPE_B))) begin
      remote_value_fwd = 8'd1;
    end
  end
  assign remote_sum_fwd = SYNC_BYTE + remote_type_r + remote_value_fwd;

  // Frame assembly, temperature tracking and burst contents.
  always_comb begin
    pool_in_frame_nxt     = pool_in_frame_r;
    pool_count_nxt        = pool_count_r;
    pool_type_nxt         = pool_type_r;
    pool_value_nxt        = pool_value_r;
    remote_in_frame_nxt   = remote_in_frame_r;
    remote_count_nxt      = remote_count_r;
    remote_type_nxt       = remote_type_r;
    remote_value_nxt      = remote_value_r;
    last_temperature_nxt  = last_temperature_r;
    temperature_known_nxt = temperature_known_r;
    burst_load            = 1'b0;
    burst_bytes_nxt[0]    = in_byte_r;
    burst_bytes_nxt[1]    = remote_type_r;
    burst_bytes_nxt[2]    = remote_value_fwd;
    burst_bytes_nxt[3]    = remote_sum_fwd;
    burst_len_nxt         = LEN_ONE;
    burst_to_pool_nxt     = 1'b0;
    burst_byte_valid_nxt  = 1'b1;
    burst_err_nxt         = 1'b0;
    burst_tupd_nxt        = 1'b0;
    burst_temp_nxt        = 8'd0;
    if (advance) begin
      if (in_action_r == SRC_POOL) begin
        // Pool byte: relay it and parse the frame it belongs to.
        burst_load = 1'b1;
        if (!pool_in_frame_r) begin
          if (in_byte_r == SYNC_BYTE) begin
            pool_in_frame_nxt = 1'b1;
            pool_count_nxt    = POS_TYPE;
          end
        end else if (!pool_complete) begin
          if (pool_count_r == POS_TYPE) begin
            pool_type_nxt = in_byte_r;
          end else begin
            pool_value_nxt = in_byte_r;
          end
          pool_count_nxt = pool_count_r + 2'd1;
        end else begin
          pool_in_frame_nxt = 1'b0;
          pool_count_nxt    = 2'd0;
          if (pool_sum != in_byte_r) begin
            burst_err_nxt = 1'b1;
          end else if ((pool_type_r == TEMP_TYPE) &&
                       (!temperature_known_r || (last_temperature_r != pool_value_r))) begin
            last_temperature_nxt  = pool_value_r;
            temperature_known_nxt = 1'b1;
            burst_tupd_nxt        = 1'b1;
            burst_temp_nxt        = pool_value_r;
          end
        end
      end else begin
        // Remote byte: hold it until the frame is complete.
        if (!remote_in_frame_r) begin
          if (in_byte_r == SYNC_BYTE) begin
            remote_in_frame_nxt = 1'b1;
            remote_count_nxt    = POS_TYPE;
          end
        end else if (!remote_complete) begin
          if (remote_count_r == POS_TYPE) begin
            remote_type_nxt = in_byte_r;
          end else begin
            remote_value_nxt = in_byte_r;
          end
          remote_count_nxt = remote_count_r + 2'd1;
        end else begin
          remote_in_frame_nxt = 1'b0;
          remote_count_nxt    = 2'd0;
          burst_load          = 1'b1;
          if (remote_sum != in_byte_r) begin
            burst_bytes_nxt[0]   = 8'd0;
            burst_byte_valid_nxt = 1'b0;
            burst_err_nxt        = 1'b1;
          end else begin
            burst_bytes_nxt[0] = SYNC_BYTE;
            burst_len_nxt      = LEN_FOUR;
            burst_to_pool_nxt  = 1'b1;
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      heater_override_r   <= 1'b0;
      pool_in_frame_r     <= 1'b0;
      pool_count_r        <= 2'd0;
      remote_in_frame_r   <= 1'b0;
      remote_count_r      <= 2'd0;
      last_temperature_r  <= 8'd0;
      temperature_known_r <= 1'b0;
      burst_valid_r       <= 1'b0;
      burst_idx_r         <= 2'd0;
    end else begin
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        heater_override_r <= cfg_heater_override;
      end
      pool_in_frame_r     <= pool_in_frame_nxt;
      pool_count_r        <= pool_count_nxt;
      remote_in_frame_r   <= remote_in_frame_nxt;
      remote_count_r      <= remote_count_nxt;
      last_temperature_r  <= last_temperature_nxt;
      temperature_known_r <= temperature_known_nxt;
      if (burst_load) begin
        burst_valid_r <= 1'b1;
        burst_idx_r   <= 2'd0;
      end else if (burst_done) begin
        burst_valid_r <= 1'b0;
        burst_idx_r   <= 2'd0;
      end else if (out_xfer) begin
        burst_idx_r <= burst_idx_r + 2'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_action_r <= in_action;
      in_byte_r   <= in_byte;
    end
    pool_type_r    <= pool_type_nxt;
    pool_value_r   <= pool_value_nxt;
    remote_type_r  <= remote_type_nxt;
    remote_value_r <= remote_value_nxt;
    if (burst_load) begin
      burst_bytes_r      <= burst_bytes_nxt;
      burst_len_r        <= burst_len_nxt;
      burst_to_pool_r    <= burst_to_pool_nxt;
      burst_byte_valid_r <= burst_byte_valid_nxt;
      burst_err_r        <= burst_err_nxt;
      burst_tupd_r       <= burst_tupd_nxt;
      burst_temp_r       <= burst_temp_nxt;
    end
  end

  // Result outputs come straight from the burst register.
  assign out_valid       = burst_valid_r;
  assign out_byte        = burst_bytes_r[burst_idx_r];
  assign out_to_pool     = burst_to_pool_r;
  assign out_byte_valid  = burst_byte_valid_r;
  assign out_last        = (burst_idx_r == burst_len_r);
  assign out_frame_error = burst_err_r;
  assign out_temp_update = burst_tupd_r;
  assign out_temperature = burst_temp_r;

  // The burst index never runs past the last result.
  `SFPR_ASSERT_RST(a_idx_in_range, clk, rst_n, burst_valid_r |-> (burst_idx_r <= burst_len_r))
  // A transfer that is not the last one leaves more results waiting.
  `SFPR_ASSERT_RST(a_burst_continues, clk, rst_n, (out_xfer && !out_last) |=> out_valid)
  // Only a rewritten remote frame produces a four-result burst, all to the pool.
  `SFPR_ASSERT_RST(a_four_to_pool, clk, rst_n,
    burst_valid_r |-> ((burst_len_r == LEN_FOUR) == burst_to_pool_r))
  // Nothing is shown on the output while reset holds.
  `SFPR_ASSERT(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule
